@@ design/deq_pkg.sv @@
// Shared types and codes for the double-ended queue.
// No dependencies; imported by the cell, chain and top-level modules.
`default_nettype none

package deq_pkg;

  localparam int WORD_W   = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;   // width of the reported item count

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_HEAD = 2'd0,
    OP_PUSH_TAIL = 2'd1,
    OP_POP_HEAD  = 2'd2,
    OP_POP_TAIL  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell of a chain does at each clock edge.
  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_UP    = 2'd1,   // take the word of the cell below (cell 0 takes the input word)
    CMD_DOWN  = 2'd2,   // take the word of the cell above
    CMD_LOAD  = 2'd3    // the cell whose index equals the count takes the input word
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                   cmd;
    logic signed [WORD_W-1:0]    word;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/deq_if.sv @@
// Valid/ready channel interfaces for the double-ended queue.
// Depends on nothing; used by double_ended_queue_top.
`default_nettype none

interface deq_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface deq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] popped_value;
  logic [4:0]         item_count;
  logic               is_empty;

  modport source (output valid, output status, output popped_value, output item_count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input popped_value, input item_count,
                  input is_empty, output ready);
endinterface

`default_nettype wire

@@ design/deq_cell.sv @@
// One storage cell of a shifting chain.
// Depends on deq_pkg.
`default_nettype none

module deq_cell
  import deq_pkg::*;
#(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  wire logic                     clk,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic [CW-1:0]            count,
  input  wire logic signed [WORD_W-1:0] lower,
  input  wire logic signed [WORD_W-1:0] upper,
  output logic signed [WORD_W-1:0]      data
);

  logic signed [WORD_W-1:0] data_next;

  always_comb begin
    case (ctrl.cmd)
      CMD_HOLD: data_next = data;
      CMD_UP:   data_next = lower;
      CMD_DOWN: data_next = upper;
      CMD_LOAD: data_next = (count == CW'(IDX)) ? ctrl.word : data;
      default:  data_next = data;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

@@ design/deq_chain.sv @@
// Row of DEPTH cells; cell 0 is the end the queue is read from.
// Depends on deq_pkg and deq_cell.
`default_nettype none

module deq_chain
  import deq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int CW    = 5
) (
  input  wire logic                 clk,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic [CW-1:0]        count,
  output logic signed [WORD_W-1:0]  first
);

  logic signed [WORD_W-1:0] cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] lower;
    logic signed [WORD_W-1:0] upper;

    if (i == 0) begin : g_lo_end
      assign lower = ctrl.word;
    end else begin : g_lo
      assign lower = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi_end
      assign upper = '0;
    end else begin : g_hi
      assign upper = cells[i+1];
    end

    deq_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .count (count),
      .lower (lower),
      .upper (upper),
      .data  (cells[i])
    );
  end

  assign first = cells[0];

endmodule

`default_nettype wire

@@ design/double_ended_queue_top.sv @@
// Top level of the double-ended queue: two cell chains, count and result register.
// Depends on deq_pkg, deq_if (deq_req_if, deq_rsp_if) and deq_chain.
//
// Usage:
//  - req channel carries one operation word: push head, push tail, pop head,
//    pop tail, plus the value to store on a push.
//  - rsp channel returns exactly one word per operation: status (ok, empty,
//    full), the popped value (zero unless a pop succeeded), the count after
//    the step and an empty flag.
//  - Storage is two rows of DEPTH cells holding the same words. The head row
//    keeps the head word in cell 0, the tail row keeps the tail word in cell 0.
//    A push at one end shifts that end's row up by one cell and loads the
//    word into the other row at the cell indexed by the count; a pop reads
//    cell 0 of its end's row and shifts that row down. Every read is at cell 0.
//  - Result: registered; it appears in the cycle after the operation is accepted.
//  - Throughput: one operation per cycle while rsp.ready is high; the count
//    register is the only loop between operations.
//  - Stall: the result register holds while rsp.ready is low and req.ready
//    drops; a new operation is taken in the same cycle the result is taken.
//  - Reset (rst, synchronous): count cleared to zero, result register empty.
//    Cell contents are not reset; only written cells are ever read.
`default_nettype none

module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic           accept;
  logic           full;
  logic           empty;
  op_t            op;
  cell_ctrl_t     head_ctrl;
  cell_ctrl_t     tail_ctrl;
  logic signed [WORD_W-1:0] head_word;
  logic signed [WORD_W-1:0] tail_word;

  // result register
  logic                     rsp_valid;
  status_t                  status;
  status_t                  status_next;
  logic signed [WORD_W-1:0] popped;
  logic signed [WORD_W-1:0] popped_next;
  logic [CW+COUNT_W-1:0]    count_ext;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign op        = op_t'(req.operation);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    head_ctrl.cmd  = CMD_HOLD;
    head_ctrl.word = req.value;
    tail_ctrl.cmd  = CMD_HOLD;
    tail_ctrl.word = req.value;
    count_next     = count;
    status_next    = ST_OK;
    popped_next    = '0;
    case (op)
      OP_PUSH_HEAD: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          head_ctrl.cmd = CMD_UP;
          tail_ctrl.cmd = CMD_LOAD;
          count_next    = count + CW'(1);
        end
      end
      OP_PUSH_TAIL: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          tail_ctrl.cmd = CMD_UP;
          head_ctrl.cmd = CMD_LOAD;
          count_next    = count + CW'(1);
        end
      end
      OP_POP_HEAD: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          // the tail row's copy of this word sits past the new count; dead
          head_ctrl.cmd = CMD_DOWN;
          popped_next   = head_word;
          count_next    = count - CW'(1);
        end
      end
      OP_POP_TAIL: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          tail_ctrl.cmd = CMD_DOWN;
          popped_next   = tail_word;
          count_next    = count - CW'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    if (!accept) begin
      head_ctrl.cmd = CMD_HOLD;
      tail_ctrl.cmd = CMD_HOLD;
      count_next    = count;
    end
  end

  deq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_head_chain (
    .clk   (clk),
    .ctrl  (head_ctrl),
    .count (count),
    .first (head_word)
  );

  deq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_tail_chain (
    .clk   (clk),
    .ctrl  (tail_ctrl),
    .count (count),
    .first (tail_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted operation
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      popped <= popped_next;
    end
  end

  // count already holds the post-step value while the result is shown
  assign count_ext        = {{COUNT_W{1'b0}}, count};
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = status;
  assign rsp.popped_value = popped;
  assign rsp.item_count   = count_ext[COUNT_W-1:0];
  assign rsp.is_empty     = empty;

endmodule

`default_nettype wire
